// ===== rtl/mi3_pkg.sv =====
// Constants, tables and types for the pipelined 3x3 fixed-point matrix inverse.
// No dependencies; imported by matrix_inverse_3x3_top and its testbench.
package mi3_pkg;

	localparam int ELEM_W     = 32;
	localparam int FRAC_BITS  = 16;
	localparam int NELEM      = 9;
	localparam int NPROD      = 2 * NELEM;
	localparam int PROD_W     = 2 * ELEM_W;
	localparam int COF_W      = PROD_W + 1;
	localparam int COF_HI_W   = COF_W - ELEM_W;
	localparam int DPP_W      = ELEM_W + COF_HI_W;
	localparam int DTERM_W    = ELEM_W + COF_W;
	localparam int DET_W      = DTERM_W + 2;
	localparam int REM_W      = DET_W + 1;
	localparam int QUO_W      = 2 * FRAC_BITS;
	localparam int DIV_STEPS  = 2;
	localparam int DIV_STAGES = QUO_W / DIV_STEPS;
	localparam int STATUS_W   = 2;
	localparam int IN_W       = NELEM * ELEM_W;
	localparam int OUT_W      = NELEM * ELEM_W;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_SINGULAR  = 2'd1,
		ST_SATURATED = 2'd2
	} status_t;

	// Operand pairs of the cofactor products: cofactor i is
	// elem[PA[2i]]*elem[PB[2i]] - elem[PA[2i+1]]*elem[PB[2i+1]].
	localparam int unsigned PA [NPROD] = '{4, 7, 2, 8, 1, 4, 5, 8, 0, 6, 2, 5, 3, 6, 1, 7, 0, 3};
	localparam int unsigned PB [NPROD] = '{8, 5, 7, 1, 5, 2, 6, 3, 8, 2, 3, 0, 7, 4, 6, 0, 4, 1};

endpackage

// ===== rtl/matrix_inverse_3x3_top.sv =====
// Top level of the pipelined 3x3 matrix inverse (adjugate over determinant).
// Depends on mi3_pkg for widths, the cofactor operand table and the status codes.
//
// Channel   Dir  Signals                      Contents
// s_axis    in   tvalid tready tdata[287:0]   matrix a_r0c0 .. a_r2c2, 32 bits each
// m_axis    out  tvalid tready tdata[287:0]   inverse inv_r0c0 .. inv_r2c2, 32 bits each
//                tuser[1:0]                   status: 0 ok, 1 singular, 2 saturated
//
// One matrix is taken per cycle while the output does not stall. There are 24
// register stages: the six arithmetic stages (products, cofactors, determinant
// partial products, determinant terms, determinant sum, magnitudes), the stage that
// loads the dividers and flags overflow, the nine restoring dividers, which retire
// two quotient bits per stage over sixteen stages, and the output register.
// Reset clears only the valid bits; data registers are not reset.
// A stall on the output freezes every stage together, so nothing is lost or
// repeated, and a new transfer is taken whenever the output register is free
// or being emptied in the same cycle.
module matrix_inverse_3x3_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [mi3_pkg::IN_W-1:0]     s_axis_tdata,   // a_r0c0 (low) .. a_r2c2 (high)
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [mi3_pkg::OUT_W-1:0]    m_axis_tdata,   // inv_r0c0 (low) .. inv_r2c2 (high)
	output logic [mi3_pkg::STATUS_W-1:0] m_axis_tuser    // status
);
	import mi3_pkg::*;

	// The whole pipeline moves when the output register can take a new value.
	logic adv;
	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	// Stage valid bits: stages 1 to 6, then the divider stages 0..DIV_STAGES.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic vld_sd [DIV_STAGES+1];

	// Input unpacking.
	logic signed [ELEM_W-1:0] elem_c [NELEM];
	always_comb begin
		for (int i = 0; i < NELEM; i++) begin
			elem_c[i] = s_axis_tdata[i*ELEM_W +: ELEM_W];
		end
	end

	// Stage 1: the eighteen 32x32 products.
	logic signed [PROD_W-1:0] prod_s1 [NPROD];
	logic signed [ELEM_W-1:0] arow_s1 [3];
	// Stage 2: the nine cofactors.
	logic signed [COF_W-1:0]  cof_s2 [NELEM];
	logic signed [ELEM_W-1:0] arow_s2 [3];
	// Stage 3: first-row times cofactor, split into low and high partial products.
	logic signed [DPP_W-1:0]  dlo_s3 [3];
	logic signed [DPP_W-1:0]  dhi_s3 [3];
	logic signed [COF_W-1:0]  cof_s3 [NELEM];
	// Stage 4: the three determinant terms.
	logic signed [DTERM_W-1:0] dterm_s4 [3];
	logic signed [COF_W-1:0]   cof_s4 [NELEM];
	// Stage 5: the determinant.
	logic signed [DET_W-1:0] det_s5;
	logic signed [COF_W-1:0] cof_s5 [NELEM];
	// Stage 6: magnitudes and signs.
	logic [DET_W-1:0] dmag_s6;
	logic [COF_W-1:0] cmag_s6 [NELEM];
	logic             neg_s6 [NELEM];
	logic             zero_s6;
	// Divider stages; index 0 holds the initial remainder and overflow flags.
	logic [REM_W-1:0] rem_sd  [DIV_STAGES+1][NELEM];
	logic [QUO_W-1:0] quo_sd  [DIV_STAGES+1][NELEM];
	logic             sath_sd [DIV_STAGES+1][NELEM];
	logic             neg_sd  [DIV_STAGES+1][NELEM];
	logic [DET_W-1:0] dmag_sd [DIV_STAGES+1];
	logic             zero_sd [DIV_STAGES+1];

	// Combinational results feeding each register stage.
	logic signed [PROD_W-1:0]  prod_c  [NPROD];
	logic signed [COF_W-1:0]   cof_c   [NELEM];
	logic signed [DPP_W-1:0]   dlo_c   [3];
	logic signed [DPP_W-1:0]   dhi_c   [3];
	logic signed [DTERM_W-1:0] dterm_c [3];
	logic signed [DET_W-1:0]   det_c;
	logic [DET_W-1:0]          dmag_c;
	logic [COF_W-1:0]          cmag_c  [NELEM];
	logic [REM_W-1:0]          rem_c   [DIV_STAGES][NELEM];
	logic [QUO_W-1:0]          quo_c   [DIV_STAGES][NELEM];

	always_comb begin
		for (int k = 0; k < NPROD; k++) begin
			prod_c[k] = elem_c[PA[k]] * elem_c[PB[k]];
		end
		for (int i = 0; i < NELEM; i++) begin
			cof_c[i] = COF_W'(prod_s1[2*i]) - COF_W'(prod_s1[2*i+1]);
		end
		for (int k = 0; k < 3; k++) begin
			dlo_c[k] = arow_s2[k] * $signed({1'b0, cof_s2[3*k][ELEM_W-1:0]});
			dhi_c[k] = arow_s2[k] * $signed(cof_s2[3*k][COF_W-1:ELEM_W]);
			dterm_c[k] = (DTERM_W'(dhi_s3[k]) <<< ELEM_W) + DTERM_W'(dlo_s3[k]);
		end
		det_c = DET_W'(dterm_s4[0]) + DET_W'(dterm_s4[1]) + DET_W'(dterm_s4[2]);
		dmag_c = det_s5[DET_W-1] ? DET_W'(-det_s5) : DET_W'(det_s5);
		for (int i = 0; i < NELEM; i++) begin
			cmag_c[i] = cof_s5[i][COF_W-1] ? COF_W'(-cof_s5[i]) : COF_W'(cof_s5[i]);
		end
	end

	// Restoring division of |cof| * 2^32 by |det|, two quotient bits per stage.
	// The remainder stays below the divisor unless sath_sd is set.
	always_comb begin
		logic [REM_W-1:0] r;
		logic [QUO_W-1:0] q;
		for (int j = 0; j < DIV_STAGES; j++) begin
			for (int i = 0; i < NELEM; i++) begin
				r = rem_sd[j][i];
				q = quo_sd[j][i];
				for (int b = 0; b < DIV_STEPS; b++) begin
					r = {r[REM_W-2:0], 1'b0};
					if (r >= {1'b0, dmag_sd[j]}) begin
						r = r - {1'b0, dmag_sd[j]};
						q = {q[QUO_W-2:0], 1'b1};
					end else begin
						q = {q[QUO_W-2:0], 1'b0};
					end
				end
				rem_c[j][i] = r;
				quo_c[j][i] = q;
			end
		end
	end

	// Final clamp, sign and status.
	logic [OUT_W-1:0]    tdata_c;
	logic [STATUS_W-1:0] tuser_c;
	always_comb begin
		logic [ELEM_W-1:0] lim;
		logic [ELEM_W-1:0] q;
		logic              over;
		logic              any_sat;
		any_sat = 1'b0;
		tdata_c = '0;
		for (int i = 0; i < NELEM; i++) begin
			q = quo_sd[DIV_STAGES][i][ELEM_W-1:0];
			lim = neg_sd[DIV_STAGES][i] ? {1'b1, {(ELEM_W-1){1'b0}}} : {1'b0, {(ELEM_W-1){1'b1}}};
			over = sath_sd[DIV_STAGES][i] || (q > lim);
			any_sat = any_sat || over;
			if (over) begin
				tdata_c[i*ELEM_W +: ELEM_W] = lim;
			end else if (neg_sd[DIV_STAGES][i]) begin
				tdata_c[i*ELEM_W +: ELEM_W] = -q;
			end else begin
				tdata_c[i*ELEM_W +: ELEM_W] = q;
			end
		end
		if (zero_sd[DIV_STAGES]) begin
			tdata_c = '0;
			tuser_c = ST_SINGULAR;
		end else if (any_sat) begin
			tuser_c = ST_SATURATED;
		end else begin
			tuser_c = ST_OK;
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			for (int j = 0; j <= DIV_STAGES; j++) begin
				vld_sd[j] <= 1'b0;
			end
			m_axis_tvalid <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_sd[0] <= vld_s6;
			for (int j = 1; j <= DIV_STAGES; j++) begin
				vld_sd[j] <= vld_sd[j-1];
			end
			m_axis_tvalid <= vld_sd[DIV_STAGES];
		end
	end

	// Data registers, no reset.
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= prod_c;
			for (int k = 0; k < 3; k++) begin
				arow_s1[k] <= elem_c[k];
			end
			cof_s2  <= cof_c;
			arow_s2 <= arow_s1;
			dlo_s3  <= dlo_c;
			dhi_s3  <= dhi_c;
			cof_s3  <= cof_s2;
			dterm_s4 <= dterm_c;
			cof_s4   <= cof_s3;
			det_s5   <= det_c;
			cof_s5   <= cof_s4;
			dmag_s6  <= dmag_c;
			cmag_s6  <= cmag_c;
			zero_s6  <= (det_s5 == '0);
			for (int i = 0; i < NELEM; i++) begin
				neg_s6[i] <= cof_s5[i][COF_W-1] ^ det_s5[DET_W-1];
			end
			// A cofactor at least as large as the determinant overflows 32 bits.
			for (int i = 0; i < NELEM; i++) begin
				rem_sd[0][i]  <= REM_W'(cmag_s6[i]);
				quo_sd[0][i]  <= '0;
				sath_sd[0][i] <= ({{(DET_W-COF_W){1'b0}}, cmag_s6[i]} >= dmag_s6);
				neg_sd[0][i]  <= neg_s6[i];
			end
			dmag_sd[0] <= dmag_s6;
			zero_sd[0] <= zero_s6;
			for (int j = 1; j <= DIV_STAGES; j++) begin
				rem_sd[j]  <= rem_c[j-1];
				quo_sd[j]  <= quo_c[j-1];
				sath_sd[j] <= sath_sd[j-1];
				neg_sd[j]  <= neg_sd[j-1];
				dmag_sd[j] <= dmag_sd[j-1];
				zero_sd[j] <= zero_sd[j-1];
			end
			m_axis_tdata <= tdata_c;
			m_axis_tuser <= tuser_c;
		end
	end

endmodule

// ===== test/tb_matrix_inverse_3x3_top.sv =====
// Self-checking testbench for matrix_inverse_3x3_top: streams 3x3 Q16.16 matrices
// and compares each inverse and status with a table or an adjugate/determinant model.
// Depends on mi3_pkg and matrix_inverse_3x3_top.
module tb_matrix_inverse_3x3_top;
	import mi3_pkg::*;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef elem_t mat_t [NELEM];

	// One inverse result: nine elements and the status code.
	typedef struct {
		logic [OUT_W-1:0] data;
		status_t          stat;
	} inverse_t;

	// Directed rows. When typed is set, the expected result is written in the row
	// itself; otherwise the behavioral model supplies it.
	typedef struct {
		logic [IN_W-1:0]  mat;
		bit               typed;
		logic [OUT_W-1:0] inv;
		status_t          stat;
	} directed_row_t;

	localparam int N_RANDOM   = 1700;
	localparam int DRAIN_WAIT = 60;

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;
	logic [STATUS_W-1:0] m_axis_tuser;

	inverse_t pending_inverses[$];
	int       mismatch_count;
	int       results_seen;
	bit       stim_done;

	matrix_inverse_3x3_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // a_r0c0 (low) .. a_r2c2 (high)
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // inv_r0c0 (low) .. inv_r2c2 (high)
		.m_axis_tuser  (m_axis_tuser)    // status
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// One element of the inverse: trunc(cof * 2^(2F) / det), clamped to the
	// element range. SystemVerilog signed division already truncates toward zero.
	function automatic elem_t inverse_element(input logic signed [255:0] cof,
			input logic signed [255:0] det, inout bit clamped);
		logic signed [255:0] q;
		logic signed [255:0] hi;
		logic signed [255:0] lo;
		hi = 256'sd2147483647;
		lo = -256'sd2147483648;
		q = (cof <<< (2 * FRAC_BITS)) / det;
		if (q > hi) begin
			clamped = 1'b1;
			q = hi;
		end else if (q < lo) begin
			clamped = 1'b1;
			q = lo;
		end
		return q[ELEM_W-1:0];
	endfunction

	// Full-width adjugate over determinant, determinant expanded along row 0.
	function automatic inverse_t invert_matrix(input logic [IN_W-1:0] packed_mat);
		logic signed [255:0] e [NELEM];
		logic signed [255:0] cof [NELEM];
		logic signed [255:0] det;
		inverse_t r;
		bit clamped;
		clamped = 1'b0;
		for (int i = 0; i < NELEM; i++)
			e[i] = $signed(packed_mat[i*ELEM_W +: ELEM_W]);
		// Elements indexed row*3+col.
		cof[0] = e[4]*e[8] - e[7]*e[5];
		cof[1] = e[2]*e[7] - e[8]*e[1];
		cof[2] = e[1]*e[5] - e[4]*e[2];
		cof[3] = e[5]*e[6] - e[8]*e[3];
		cof[4] = e[0]*e[8] - e[6]*e[2];
		cof[5] = e[2]*e[3] - e[5]*e[0];
		cof[6] = e[3]*e[7] - e[6]*e[4];
		cof[7] = e[1]*e[6] - e[7]*e[0];
		cof[8] = e[0]*e[4] - e[3]*e[1];
		det = e[0]*cof[0] - e[1]*(e[3]*e[8] - e[6]*e[5]) + e[2]*cof[6];
		r.data = '0;
		if (det == 0) begin
			r.stat = ST_SINGULAR;
			return r;
		end
		for (int i = 0; i < NELEM; i++)
			r.data[i*ELEM_W +: ELEM_W] = inverse_element(cof[i], det, clamped);
		r.stat = clamped ? ST_SATURATED : ST_OK;
		return r;
	endfunction

	function automatic logic [IN_W-1:0] pack_matrix(input mat_t m);
		logic [IN_W-1:0] p;
		for (int i = 0; i < NELEM; i++)
			p[i*ELEM_W +: ELEM_W] = m[i];
		return p;
	endfunction

	function automatic logic [IN_W-1:0] scaled_identity(input elem_t d);
		mat_t m;
		for (int i = 0; i < NELEM; i++)
			m[i] = (i % 4 == 0) ? d : '0;
		return pack_matrix(m);
	endfunction

	function automatic logic [IN_W-1:0] all_same(input elem_t v);
		mat_t m;
		for (int i = 0; i < NELEM; i++)
			m[i] = v;
		return pack_matrix(m);
	endfunction

	// Random element with a mix of magnitudes: small Q16.16 values give ordinary
	// inverses, full-range values exercise saturation and wide cofactors.
	function automatic elem_t random_element();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return $signed($urandom_range(0, 8)) - 4 <<< 16;
			2: return $signed($urandom_range(0, 32'h0003_ffff)) - 32'sh0002_0000;
			3: return $urandom_range(0, 1) ? 32'sh7fff_ffff : -32'sh8000_0000;
			default: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
		endcase
	endfunction

	// Random matrix; some singular (copied or zeroed row), some diagonal.
	function automatic logic [IN_W-1:0] random_matrix();
		mat_t m;
		int src;
		for (int i = 0; i < NELEM; i++)
			m[i] = random_element();
		case ($urandom_range(0, 9))
			0: begin
				src = $urandom_range(0, 1);
				for (int c = 0; c < 3; c++)
					m[6 + c] = m[src*3 + c];
			end
			1: for (int c = 0; c < 3; c++) m[3 + c] = '0;
			2: for (int i = 0; i < NELEM; i++) if (i % 4 != 0) m[i] = '0;
			default: ;
		endcase
		return pack_matrix(m);
	endfunction

	// Half the time no gap, otherwise mostly a short one, occasionally a long one.
	function automatic int gap_length();
		int n;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: n = 0;
			9: n = $urandom_range(10, 40);
			default: n = $urandom_range(1, 3);
		endcase
		return n;
	endfunction

	task automatic random_gap();
		repeat (gap_length()) @(negedge clk);
	endtask

	// Sender pause: valid drops only when a nonzero gap is drawn.
	task automatic sender_gap();
		int n;
		n = gap_length();
		if (n > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// Drive one matrix and hold it until the transfer happens. The expected
	// inverse is queued at the accepting edge so ordering matches the block.
	// Valid stays high afterwards so the next matrix can follow without a gap.
	task automatic send_matrix(input logic [IN_W-1:0] mat, input inverse_t want);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= mat;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_inverses.push_back(want);
		@(negedge clk);
	endtask

	// Stimulus: directed table, a full drain, then random matrices.
	initial begin
		directed_row_t rows[$];
		directed_row_t row;
		inverse_t want;
		logic [IN_W-1:0] m;

		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		stim_done     = 1'b0;
		arst_n        = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Identity in Q16.16 inverts to itself.
		rows.push_back('{scaled_identity(32'sh0001_0000), 1'b1,
			scaled_identity(32'sh0001_0000), ST_OK});
		// Twice the identity gives one half on the diagonal.
		rows.push_back('{scaled_identity(32'sh0002_0000), 1'b1,
			scaled_identity(32'sh0000_8000), ST_OK});
		rows.push_back('{scaled_identity(-32'sh0001_0000), 1'b1,
			scaled_identity(-32'sh0001_0000), ST_OK});
		// Zero matrix and rank-one matrices are singular with all-zero output.
		rows.push_back('{all_same('0), 1'b1, '0, ST_SINGULAR});
		rows.push_back('{all_same(32'sh7fff_ffff), 1'b1, '0, ST_SINGULAR});
		rows.push_back('{all_same(-32'sh8000_0000), 1'b1, '0, ST_SINGULAR});
		rows.push_back('{all_same(32'sh0001_0000), 1'b1, '0, ST_SINGULAR});
		// Tiny diagonal: the inverse overflows and clamps to the positive limit.
		rows.push_back('{scaled_identity(32'sh0000_0001), 1'b1,
			scaled_identity(32'sh7fff_ffff), ST_SATURATED});
		// Negative tiny diagonal clamps to the negative limit.
		rows.push_back('{scaled_identity(-32'sh0000_0001), 1'b1,
			scaled_identity(-32'sh8000_0000), ST_SATURATED});
		// Largest magnitudes on the diagonal and other model-checked cases.
		rows.push_back('{scaled_identity(32'sh7fff_ffff), 1'b0, '0, ST_OK});
		rows.push_back('{scaled_identity(-32'sh8000_0000), 1'b0, '0, ST_OK});
		rows.push_back('{pack_matrix('{32'sh0002_0000, 32'sh0001_0000, 0,
			32'sh0001_0000, 32'sh0003_0000, 32'sh0001_0000,
			0, 32'sh0001_0000, 32'sh0004_0000}), 1'b0, '0, ST_OK});
		rows.push_back('{pack_matrix('{0, 32'sh0001_0000, 0, 0, 0, 32'sh0001_0000,
			32'sh0001_0000, 0, 0}), 1'b0, '0, ST_OK});
		rows.push_back('{pack_matrix('{-32'sh8000_0000, 32'sh7fff_ffff, 1,
			32'sh7fff_ffff, -32'sh8000_0000, -1, 1, -1, -32'sh8000_0000}),
			1'b0, '0, ST_OK});
		rows.push_back('{pack_matrix('{32'sh5555_5555, -32'sh2aaa_aaab, 32'sh1234_5678,
			32'sh0f0f_0f0f, 32'sh7fff_0000, -32'sh0001_0000,
			-32'sh7654_3210, 32'sh0000_ffff, 32'sh3333_3333}), 1'b0, '0, ST_OK});
		// Mixed: a small, a large and a unit diagonal element; none of them clamps.
		rows.push_back('{pack_matrix('{32'sh0000_0100, 0, 0, 0, 32'sh0100_0000, 0,
			0, 0, 32'sh0001_0000}), 1'b0, '0, ST_OK});

		foreach (rows[i]) begin
			row = rows[i];
			want = invert_matrix(row.mat);
			if (row.typed) begin
				want.data = row.inv;
				want.stat = row.stat;
			end
			send_matrix(row.mat, want);
			sender_gap();
		end

		// Hold the sender until every expected inverse has been delivered.
		s_axis_tvalid <= 1'b0;
		while (pending_inverses.size() != 0) @(negedge clk);

		for (int n = 0; n < N_RANDOM; n++) begin
			m = random_matrix();
			send_matrix(m, invert_matrix(m));
			if ($urandom_range(0, 99) < 40)
				sender_gap();
		end
		s_axis_tvalid <= 1'b0;
		stim_done = 1'b1;
	end

	// Receiver back-pressure: long ready stretches with random stalls.
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(negedge clk);
			if ($urandom_range(0, 1)) begin
				m_axis_tready <= 1'b0;
				random_gap();
				@(negedge clk);
			end
		end
	end

	// Compare every output transfer with the oldest expected inverse.
	always @(posedge clk) begin
		inverse_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (pending_inverses.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected output transfer: data=%h status=%0d",
						m_axis_tdata, m_axis_tuser);
			end else begin
				want = pending_inverses.pop_front();
				for (int i = 0; i < NELEM; i++) begin
					if (m_axis_tdata[i*ELEM_W +: ELEM_W] !== want.data[i*ELEM_W +: ELEM_W]) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("result %0d element %0d: expected %h got %h",
								results_seen, i, want.data[i*ELEM_W +: ELEM_W],
								m_axis_tdata[i*ELEM_W +: ELEM_W]);
					end
				end
				if (m_axis_tuser !== want.stat) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result %0d status: expected %0d got %0d",
							results_seen, want.stat, m_axis_tuser);
				end
			end
		end
	end

	// End of run: drain, settle, then report.
	initial begin
		mismatch_count = 0;
		results_seen   = 0;
		wait (stim_done);
		while (pending_inverses.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0 && pending_inverses.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog; far beyond the slowest legitimate run.
	initial begin
		#4000000;
		$display("status: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/mi3_pkg.sv
rtl/matrix_inverse_3x3_top.sv
test/tb_matrix_inverse_3x3_top.sv
